### src/assert_macros.svh
// Assertion macros used by the top level of the PLL coefficient calculator.
// Depends on nothing; the including module must have aclk and aresetn.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property checked at every rising edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Same-cycle implication checked at every rising edge outside reset.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

### src/pmc_pkg.sv
// Package of the PLL coefficient calculator: field widths, register indexes
// and defaults. Depends on nothing.
package pmc_pkg;

    localparam int FREQ_W    = 28;
    localparam int XTAL_W    = 26;
    localparam int VCO_W     = 30;
    localparam int CFG_W     = 30;
    localparam int DIV_W     = 12;
    localparam int FBI_W     = 7;
    localparam int NUMR_W    = 20;
    localparam int P1_W      = 18;
    localparam int P2_W      = 20;
    localparam int S_DATA_W  = 32;
    localparam int M_DATA_W  = 96;

    localparam int DEFAULT_FRAC_DENOM = 1048575;

    localparam logic [XTAL_W-1:0] XTAL_RESET = XTAL_W'(25000000);
    localparam logic [VCO_W-1:0]  VCO_RESET  = VCO_W'(600000000);

    // Configuration register indexes.
    localparam logic REG_XTAL = 1'b0;
    localparam logic REG_VCO  = 1'b1;

    localparam logic [DIV_W-1:0] DIV_MIN = DIV_W'(4);
    localparam logic [DIV_W-1:0] DIV_MAX = DIV_W'(2048);
    localparam logic [FBI_W-1:0] FBI_MIN = FBI_W'(4);

endpackage

### src/pmc_pipe_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on nothing; instantiated by pll_multisynth_param_calc.
module pmc_pipe_div #(
    parameter int NUM_W  = 31,
    parameter int DEN_W  = 28,
    parameter int Q_W    = 12,
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side,
    output logic              out_valid,
    output logic [Q_W-1:0]    quo,
    output logic [DEN_W-1:0]  rem,
    output logic [SIDE_W-1:0] out_side
);

    // The quotient is assumed to fit in Q_W bits (num < den * 2**Q_W).
    localparam int W = DEN_W + Q_W;

    logic [W-1:0]      rem_reg  [Q_W];
    logic [DEN_W-1:0]  den_reg  [Q_W];
    logic [Q_W-1:0]    quo_reg  [Q_W];
    logic [SIDE_W-1:0] side_reg [Q_W];
    logic [Q_W-1:0]    valid_reg;

    for (genvar k = 0; k < Q_W; k++) begin : g_step
        logic [W-1:0]      rem_in;
        logic [DEN_W-1:0]  den_in;
        logic [Q_W-1:0]    quo_in;
        logic [SIDE_W-1:0] side_in;
        logic              v_in;
        logic [W-1:0]      trial;
        logic              take;
        logic [W-1:0]      rem_next;
        logic [Q_W-1:0]    quo_next;

        if (k == 0) begin : g_first
            assign rem_in  = W'(num);
            assign den_in  = den;
            assign quo_in  = '0;
            assign side_in = side;
            assign v_in    = in_valid;
        end else begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign quo_in  = quo_reg[k-1];
            assign side_in = side_reg[k-1];
            assign v_in    = valid_reg[k-1];
        end

        assign trial = W'(den_in) << (Q_W - 1 - k);
        assign take  = (rem_in >= trial);

        always_comb begin
            rem_next = take ? (rem_in - trial) : rem_in;
            quo_next = quo_in;
            quo_next[Q_W-1-k] = take;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_next;
                den_reg[k]  <= den_in;
                quo_reg[k]  <= quo_next;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[Q_W-1];
    assign quo       = quo_reg[Q_W-1];
    assign rem       = rem_reg[Q_W-1][DEN_W-1:0];
    assign out_side  = side_reg[Q_W-1];

endmodule

### src/pll_multisynth_param_calc.sv
// Top level of the fractional-N PLL and output divider coefficient calculator.
// Depends on pmc_pkg, pmc_pipe_div and assert_macros.svh.
//
// Each word on the input stream is a wanted output frequency in hertz; each
// word on the result stream carries the output divider d = ceil(vco/freq),
// the feedback ratio d*freq/xtal split into an integer part a and a numerator
// b rounded half up over FRAC_DENOM, and the register words P1, P2 and the
// output P1 = 128d-512. The block is one pipeline that takes a new word in
// every cycle unless the result register waits on m_tready. A word passes
// 8 + 12 + 7 + log2-width-of-FRAC_DENOM register stages (47 at the default
// denominator), the first of them loaded at the accepting edge. The depth is
// set by the three restoring dividers that produce one quotient bit per
// stage; the split of 128b by the constant denominator uses a reciprocal
// multiplication and takes one stage. All stages advance together, so the
// pipeline holds its contents while the result register waits on m_tready,
// and the input is stalled for exactly those cycles. A zero frequency, a zero
// crystal, a divider outside 4..2048 or a feedback integer outside 4..127
// raises m_tuser with all data fields zero. The two configuration registers
// must only be written while no word is in flight.
module pll_multisynth_param_calc #(
    parameter int FRAC_DENOM = pmc_pkg::DEFAULT_FRAC_DENOM
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // Bits from low: freq_hz[27:0], zero fill.
    input  logic [pmc_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // Bits from low: out_divider[11:0], fb_integer[18:12],
    // fb_numerator[38:19], fb_p1[56:39], fb_p2[76:57], out_p1[94:77], zero fill.
    output logic [pmc_pkg::M_DATA_W-1:0]  m_tdata,
    // Bits from low: range_error.
    output logic                          m_tuser,
    input  logic                          cfg_we,
    input  logic                          cfg_addr,
    input  logic [pmc_pkg::CFG_W-1:0]     cfg_wdata
);
    import pmc_pkg::*;

    localparam int FRAC_W = $clog2(FRAC_DENOM + 1);
    localparam int DVD_W  = 31;
    localparam int Q4_W   = 8;
    localparam int N3_W   = XTAL_W + 1 + FRAC_W;
    localparam logic [FRAC_W-1:0] DENOM = FRAC_W'(FRAC_DENOM);

    // Reciprocal of the denominator for the split of x = 128b, x < 2**X4_W.
    // With RS_W = X4_W + FRAC_W the product x * RECIP shifted down by RS_W is
    // exactly floor(x / FRAC_DENOM) over the whole range of x.
    localparam int X4_W = FRAC_W + 7;
    localparam int RS_W = X4_W + FRAC_W;
    localparam int RM_W = X4_W + 2;
    localparam int GP_W = X4_W + RM_W;
    localparam logic [RM_W-1:0] RECIP =
        RM_W'(((64'd1 << RS_W) + 64'(FRAC_DENOM) - 64'd1) / 64'(FRAC_DENOM));

    // Configuration registers.
    logic [XTAL_W-1:0] xtal_reg;
    logic [VCO_W-1:0]  vco_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            xtal_reg <= XTAL_RESET;
            vco_reg  <= VCO_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_XTAL: xtal_reg <= cfg_wdata[XTAL_W-1:0];
                REG_VCO:  vco_reg  <= cfg_wdata[VCO_W-1:0];
                default:  ;
            endcase
        end
    end

    // The whole pipeline moves when the result register is free or drained.
    logic en;
    logic m_valid_reg;
    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    // Stage A: capture the frequency and form vco + freq - 1.
    logic              a_valid_reg;
    logic [FREQ_W-1:0] a_freq_reg;
    logic [DVD_W-1:0]  a_dvd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_freq_reg <= s_tdata[FREQ_W-1:0];
            a_dvd_reg  <= DVD_W'(vco_reg) + DVD_W'(s_tdata[FREQ_W-1:0]) - DVD_W'(1);
        end
    end

    // Stage B: early error checks; a divider of 4096 or more is caught here
    // so the first divider only needs twelve quotient bits.
    logic              b_valid_reg;
    logic [FREQ_W-1:0] b_freq_reg;
    logic [DVD_W-1:0]  b_dvd_reg;
    logic              b_err_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (en) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_freq_reg <= a_freq_reg;
            b_dvd_reg  <= a_dvd_reg;
            b_err_reg  <= (a_freq_reg == '0) || (xtal_reg == '0) ||
                          ((FREQ_W + DIV_W)'(a_dvd_reg) >= {a_freq_reg, {DIV_W{1'b0}}});
        end
    end

    // Divider 1: d = ceil(vco / freq).
    logic              d1_valid;
    logic [DIV_W-1:0]  d1_quo;
    logic [FREQ_W-1:0] d1_rem;
    logic [FREQ_W:0]   d1_side;

    pmc_pipe_div #(
        .NUM_W(DVD_W), .DEN_W(FREQ_W), .Q_W(DIV_W), .SIDE_W(FREQ_W + 1)
    ) u_div_d (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(b_valid_reg), .num(b_dvd_reg), .den(b_freq_reg),
        .side({b_err_reg, b_freq_reg}),
        .out_valid(d1_valid), .quo(d1_quo), .rem(d1_rem), .out_side(d1_side)
    );

    // Stage C: range check on d and the product d * freq.
    logic             c_valid_reg;
    logic             c_err_reg;
    logic [DIV_W-1:0] c_d_reg;
    logic [DVD_W-1:0] c_prod_reg;
    logic [DIV_W+FREQ_W-1:0] c_prod_full;

    assign c_prod_full = (DIV_W + FREQ_W)'(d1_quo) * (DIV_W + FREQ_W)'(d1_side[FREQ_W-1:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (en) begin
            c_valid_reg <= d1_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_err_reg  <= d1_side[FREQ_W] || (d1_quo < DIV_MIN) || (d1_quo > DIV_MAX) ||
                          (d1_rem != d1_rem);
            c_d_reg    <= d1_quo;
            c_prod_reg <= c_prod_full[DVD_W-1:0];
        end
    end

    // Stage D: a feedback integer of 128 or more is an error.
    logic             d_valid_reg;
    logic             d_err_reg;
    logic [DIV_W-1:0] d_d_reg;
    logic [DVD_W-1:0] d_num_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (en) begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_err_reg <= c_err_reg ||
                         ((XTAL_W + FBI_W)'(c_prod_reg) >= {xtal_reg, {FBI_W{1'b0}}});
            d_d_reg   <= c_d_reg;
            d_num_reg <= c_prod_reg;
        end
    end

    // Divider 2: a and rem from d * freq / xtal.
    logic              d2_valid;
    logic [FBI_W-1:0]  d2_quo;
    logic [XTAL_W-1:0] d2_rem;
    logic [DIV_W:0]    d2_side;

    pmc_pipe_div #(
        .NUM_W(DVD_W), .DEN_W(XTAL_W), .Q_W(FBI_W), .SIDE_W(DIV_W + 1)
    ) u_div_a (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(d_valid_reg), .num(d_num_reg), .den(xtal_reg),
        .side({d_err_reg, d_d_reg}),
        .out_valid(d2_valid), .quo(d2_quo), .rem(d2_rem), .out_side(d2_side)
    );

    // Stage E: check a and multiply the remainder by the denominator.
    logic                     e_valid_reg;
    logic                     e_err_reg;
    logic [DIV_W-1:0]         e_d_reg;
    logic [FBI_W-1:0]         e_a_reg;
    logic [XTAL_W+FRAC_W-1:0] e_prod_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
        end else if (en) begin
            e_valid_reg <= d2_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e_err_reg  <= d2_side[DIV_W] || (d2_quo < FBI_MIN);
            e_d_reg    <= d2_side[DIV_W-1:0];
            e_a_reg    <= d2_quo;
            e_prod_reg <= (XTAL_W + FRAC_W)'(d2_rem) * (XTAL_W + FRAC_W)'(DENOM);
        end
    end

    // Stage F: rounding numerator 2 * rem * c + xtal.
    logic             f_valid_reg;
    logic             f_err_reg;
    logic [DIV_W-1:0] f_d_reg;
    logic [FBI_W-1:0] f_a_reg;
    logic [N3_W-1:0]  f_num_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (en) begin
            f_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f_err_reg <= e_err_reg;
            f_d_reg   <= e_d_reg;
            f_a_reg   <= e_a_reg;
            f_num_reg <= {e_prod_reg, 1'b0} + N3_W'(xtal_reg);
        end
    end

    // Divider 3: b = (2 * rem * c + xtal) / (2 * xtal).
    logic                    d3_valid;
    logic [FRAC_W-1:0]       d3_quo;
    logic [XTAL_W:0]         d3_rem;
    logic [DIV_W+FBI_W:0]    d3_side;

    pmc_pipe_div #(
        .NUM_W(N3_W), .DEN_W(XTAL_W + 1), .Q_W(FRAC_W), .SIDE_W(DIV_W + FBI_W + 1)
    ) u_div_b (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(f_valid_reg), .num(f_num_reg), .den({xtal_reg, 1'b0}),
        .side({f_err_reg, f_d_reg, f_a_reg}),
        .out_valid(d3_valid), .quo(d3_quo), .rem(d3_rem), .out_side(d3_side)
    );

    // Stage G: q = 128b / c by the reciprocal product; b never exceeds c, so
    // q is at most 128. The remainder P2 is formed in the result stage.
    logic              g_valid_reg;
    logic              g_err_reg;
    logic [DIV_W-1:0]  g_d_reg;
    logic [FBI_W-1:0]  g_a_reg;
    logic [FRAC_W-1:0] g_b_reg;
    logic [Q4_W-1:0]   g_q_reg;
    logic [GP_W-1:0]   g_prod;

    assign g_prod = GP_W'({d3_quo, 7'b0}) * GP_W'(RECIP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g_valid_reg <= 1'b0;
        end else if (en) begin
            g_valid_reg <= d3_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            g_err_reg <= d3_side[DIV_W+FBI_W] || (d3_rem != d3_rem);
            g_d_reg   <= d3_side[DIV_W+FBI_W-1:FBI_W];
            g_a_reg   <= d3_side[FBI_W-1:0];
            g_b_reg   <= d3_quo;
            g_q_reg   <= g_prod[RS_W +: Q4_W];
        end
    end

    // Result register.
    logic              m_err_reg;
    logic [DIV_W-1:0]  m_div_reg;
    logic [FBI_W-1:0]  m_fbi_reg;
    logic [NUMR_W-1:0] m_numr_reg;
    logic [P1_W-1:0]   m_fbp1_reg;
    logic [P2_W-1:0]   m_fbp2_reg;
    logic [P1_W-1:0]   m_op1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= g_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_err_reg <= g_err_reg;
            if (g_err_reg) begin
                m_div_reg  <= '0;
                m_fbi_reg  <= '0;
                m_numr_reg <= '0;
                m_fbp1_reg <= '0;
                m_fbp2_reg <= '0;
                m_op1_reg  <= '0;
            end else begin
                m_div_reg  <= g_d_reg;
                m_fbi_reg  <= g_a_reg;
                m_numr_reg <= NUMR_W'(g_b_reg);
                m_fbp1_reg <= P1_W'({g_a_reg, 7'b0}) + P1_W'(g_q_reg) - P1_W'(512);
                m_fbp2_reg <= P2_W'(X4_W'({g_b_reg, 7'b0}) -
                                    X4_W'(g_q_reg) * X4_W'(DENOM));
                m_op1_reg  <= P1_W'({g_d_reg, 7'b0}) - P1_W'(512);
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_err_reg;
    assign m_tdata  = M_DATA_W'({m_op1_reg, m_fbp2_reg, m_fbp1_reg,
                                 m_numr_reg, m_fbi_reg, m_div_reg});

`include "assert_macros.svh"

    `ASSERT_IMPL(a_err_zero, m_tvalid && m_tuser, m_tdata == '0, "error word carries data")
    `ASSERT_IMPL(a_div_range, m_tvalid && !m_tuser, (m_div_reg >= DIV_MIN) && (m_div_reg <= DIV_MAX), "divider out of range")
    `ASSERT_IMPL(a_op1, m_tvalid && !m_tuser, m_op1_reg == P1_W'({m_div_reg, 7'b0}) - P1_W'(512), "output P1 mismatch")
    `ASSERT_IMPL(a_p2, m_tvalid && !m_tuser, m_fbp2_reg < P2_W'(DENOM), "P2 not below denominator")

endmodule
